// ===== rtl/core/ukm_pkg.sv =====
// Shared types, codes and helpers for the unique-prefix keyword matcher.
`timescale 1ns / 1ps

package ukm_pkg;

	// Fixed field widths of the ports
	localparam int unsigned CMD_W   = 1;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned BYTES_W = 64;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned LIST_W  = 5;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned STAT_W  = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_EXACT     = 3'd0,
		ST_ABBREV    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_AMBIGUOUS = 3'd3,
		ST_LOADED    = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic {
		S_IDLE,
		S_SCAN
	} fsm_t;

	// Compare unit result
	typedef struct packed {
		logic cand;   // entry starts with the word and is long enough
		logic exact;  // candidate with the same length
	} cmp_res_t;

	// Mask covering the low len bytes; len is already clamped to 8
	function automatic logic [BYTES_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [BYTES_W-1:0] m;
		if (len >= LEN_W'(8)) begin
			m = '1;
		end else begin
			m = (BYTES_W'(1) << {len, 3'b000}) - BYTES_W'(1);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/unique_prefix_keyword_matcher_unit.sv =====
// Load result: registered in the output register in the cycle after the input beat. Lookup
// result: entries are read in order up to min(list_length, MAX_ENTRIES), and the scan ends
// early on an exact or ambiguous hit; an empty list ends the scan without any table read.
// One entry is read per cycle and compared in the next cycle, from the registered read data;
// in_ready stays low while a lookup scans, so one item is in flight at a time.
// Reset clears the sequencer, output register and list_length; table stays undefined.
`timescale 1ns / 1ps

module unique_prefix_keyword_matcher_unit #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned MAX_CHARS   = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ukm_pkg::CMD_W-1:0]    cmd,
	input  logic [ukm_pkg::SLOT_W-1:0]   entry_index,
	input  logic [ukm_pkg::BYTES_W-1:0]  text_bytes,
	input  logic [ukm_pkg::LEN_W-1:0]    text_length,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ukm_pkg::POS_W-1:0]    position,
	output logic [ukm_pkg::STAT_W-1:0]   status,
	// config channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ukm_pkg::LIST_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TXT_W = 8 * MAX_CHARS;

	ukm_pkg::fsm_t             state_q, state_d;
	logic [ukm_pkg::LIST_W-1:0] list_length_q;

	logic [TXT_W-1:0]          word_q;
	logic [TXT_W-1:0]          mask_q;
	logic [ukm_pkg::LEN_W-1:0] len_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          rd_cnt_q;
	logic                      pend_q;
	logic [CNT_W-1:0]          pend_idx_q;
	logic                      have_first_q;
	logic [CNT_W-1:0]          first_q;

	logic                      out_valid_q;
	logic [ukm_pkg::POS_W-1:0] position_q;
	ukm_pkg::status_t          status_q;

	logic                      in_fire, out_fire;
	logic [ukm_pkg::LEN_W-1:0] len_sat;
	logic [ukm_pkg::BYTES_W-1:0] mask_in;
	logic [CNT_W-1:0]          cnt_sat;
	logic                      load_wr;
	logic                      issue;
	logic                      fin;
	logic                      set_first;
	logic [ukm_pkg::POS_W-1:0] fin_pos;
	ukm_pkg::status_t          fin_status;
	logic [CNT_W:0]            pend_inc;
	logic [CNT_W:0]            first_inc;

	logic [TXT_W-1:0]          rd_text;
	logic [ukm_pkg::LEN_W-1:0] rd_len;
	ukm_pkg::cmp_res_t         cmp_res;

	// Handshakes
	assign in_ready  = (state_q == ukm_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign cfg_ready = 1'b1;

	// Input conditioning: clamp length, build byte mask, clamp list length
	assign len_sat = (text_length > ukm_pkg::LEN_W'(MAX_CHARS))
	               ? ukm_pkg::LEN_W'(MAX_CHARS) : text_length;
	assign mask_in = ukm_pkg::byte_mask(len_sat);
	assign cnt_sat = (32'(list_length_q) > MAX_ENTRIES)
	               ? CNT_W'(MAX_ENTRIES) : CNT_W'(list_length_q);
	assign load_wr = in_fire && (cmd == ukm_pkg::CMD_LOAD)
	               && (32'(entry_index) < MAX_ENTRIES);

	// Table read runs while entries remain
	assign issue = (state_q == ukm_pkg::S_SCAN) && (rd_cnt_q != count_q);

	assign pend_inc  = {1'b0, pend_idx_q} + (CNT_W + 1)'(1);
	assign first_inc = {1'b0, first_q} + (CNT_W + 1)'(1);

	ukm_table #(
		.DEPTH (MAX_ENTRIES),
		.IDX_W (IDX_W),
		.TXT_W (TXT_W)
	) u_table (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (IDX_W'(entry_index)),
		.wr_text (text_bytes[TXT_W-1:0] & mask_in[TXT_W-1:0]),
		.wr_len  (len_sat),
		.rd_en   (issue),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_text (rd_text),
		.rd_len  (rd_len)
	);

	ukm_cmp #(
		.TXT_W (TXT_W)
	) u_cmp (
		.entry_text (rd_text),
		.entry_len  (rd_len),
		.word       (word_q),
		.mask       (mask_q),
		.len        (len_q),
		.res        (cmp_res)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ukm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and scan decisions
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		set_first  = 1'b0;
		fin_pos    = '0;
		fin_status = ukm_pkg::ST_NOT_FOUND;
		case (state_q)
			ukm_pkg::S_IDLE: begin
				if (in_fire && (cmd == ukm_pkg::CMD_LOOKUP)) begin
					state_d = ukm_pkg::S_SCAN;
				end
			end
			ukm_pkg::S_SCAN: begin
				if (pend_q && cmp_res.cand) begin
					if (cmp_res.exact) begin
						fin        = 1'b1;
						fin_pos    = ukm_pkg::POS_W'(pend_inc);
						fin_status = ukm_pkg::ST_EXACT;
					end else if (have_first_q) begin
						fin        = 1'b1;
						fin_status = ukm_pkg::ST_AMBIGUOUS;
					end else begin
						set_first  = 1'b1;
					end
				end else if (!pend_q && (rd_cnt_q == count_q)) begin
					// all entries seen
					fin = 1'b1;
					if (have_first_q) begin
						fin_pos    = ukm_pkg::POS_W'(first_inc);
						fin_status = ukm_pkg::ST_ABBREV;
					end
				end
				if (fin) begin
					state_d = ukm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ukm_pkg::S_IDLE;
			end
		endcase
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			list_length_q <= cfg_data;
		end
	end

	// Lookup word capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q  <= text_bytes[TXT_W-1:0] & mask_in[TXT_W-1:0];
			mask_q  <= mask_in[TXT_W-1:0];
			len_q   <= len_sat;
			count_q <= cnt_sat;
		end
	end

	// Scan counters and first-candidate tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q     <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			have_first_q <= 1'b0;
			first_q      <= '0;
		end else begin
			if (in_fire) begin
				rd_cnt_q     <= '0;
				pend_q       <= 1'b0;
				have_first_q <= 1'b0;
			end else begin
				pend_q <= issue && !fin;
				if (issue) begin
					rd_cnt_q   <= rd_cnt_q + CNT_W'(1);
					pend_idx_q <= rd_cnt_q;
				end
				if (set_first) begin
					have_first_q <= 1'b1;
					first_q      <= pend_idx_q;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			position_q  <= '0;
			status_q    <= ukm_pkg::ST_NOT_FOUND;
		end else begin
			if (in_fire && (cmd == ukm_pkg::CMD_LOAD)) begin
				out_valid_q <= 1'b1;
				position_q  <= '0;
				status_q    <= ukm_pkg::ST_LOADED;
			end else if (fin) begin
				out_valid_q <= 1'b1;
				position_q  <= fin_pos;
				status_q    <= fin_status;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule

// ===== rtl/core/ukm_table.sv =====
// Keyword table: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ukm_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4,
	parameter int unsigned TXT_W = 64
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [TXT_W-1:0]           wr_text,
	input  logic [ukm_pkg::LEN_W-1:0]  wr_len,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_addr,
	output logic [TXT_W-1:0]           rd_text,
	output logic [ukm_pkg::LEN_W-1:0]  rd_len
);

	logic [TXT_W-1:0]          text_mem [DEPTH];
	logic [ukm_pkg::LEN_W-1:0] len_mem  [DEPTH];
	logic [TXT_W-1:0]          rd_text_q;
	logic [ukm_pkg::LEN_W-1:0] rd_len_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[wr_addr] <= wr_text;
			len_mem[wr_addr]  <= wr_len;
		end
	end

	// Read port, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_text_q <= text_mem[rd_addr];
			rd_len_q  <= len_mem[rd_addr];
		end
	end

	assign rd_text = rd_text_q;
	assign rd_len  = rd_len_q;

endmodule

// ===== rtl/core/ukm_cmp.sv =====
// Shared compare unit: tests one table entry against the lookup word.
`timescale 1ns / 1ps

module ukm_cmp #(
	parameter int unsigned TXT_W = 64
) (
	input  logic [TXT_W-1:0]           entry_text,
	input  logic [ukm_pkg::LEN_W-1:0]  entry_len,
	input  logic [TXT_W-1:0]           word,
	input  logic [TXT_W-1:0]           mask,
	input  logic [ukm_pkg::LEN_W-1:0]  len,
	output ukm_pkg::cmp_res_t          res
);

	logic long_enough;
	logic prefix_eq;

	// Entry must be at least as long and agree on the word's bytes
	assign long_enough = (entry_len >= len);
	assign prefix_eq   = ((entry_text & mask) == word);
	assign res.cand    = long_enough & prefix_eq;
	assign res.exact   = long_enough & prefix_eq & (entry_len == len);

endmodule

// ===== rtl/core/ukm_chk.sv =====
// Port-level checker for the keyword matcher, bound to the top level.
`timescale 1ns / 1ps

module ukm_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [ukm_pkg::CMD_W-1:0]   cmd,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ukm_pkg::POS_W-1:0]   position,
	input logic [ukm_pkg::STAT_W-1:0]  status
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(status))
		else $error("result beat changed while stalled");

	// Load, not-found and ambiguous results carry no position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ukm_pkg::ST_LOADED || status == ukm_pkg::ST_NOT_FOUND
		|| status == ukm_pkg::ST_AMBIGUOUS) |-> position == '0)
		else $error("position set on a result without a match");

	// A match always names an entry
	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ukm_pkg::ST_EXACT || status == ukm_pkg::ST_ABBREV)
		|-> position != '0)
		else $error("match reported without a position");

	// A lookup blocks the input while the table is scanned
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == ukm_pkg::CMD_LOOKUP |=> !in_ready)
		else $error("input taken during a lookup scan");

endmodule

bind unique_prefix_keyword_matcher_unit ukm_chk u_ukm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.position  (position),
	.status    (status)
);

// ===== bench/tb_unique_prefix_keyword_matcher_unit.sv =====
// Self-checking bench for the unique-prefix keyword matcher: table loads, lookups, list lengths.
`timescale 1ns / 1ps

module tb_unique_prefix_keyword_matcher_unit;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned WORD_BYTES  = 8;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 128;
	localparam int unsigned SETTLE_CYC  = 24;
	// list_length per random phase; negative picks a random value
	localparam int LIST_PLAN [PHASES] = '{16, 31, 0, 1, 8, -1, 5, -1, 16, 12};

	typedef struct {
		logic [ukm_pkg::CMD_W-1:0]   op;
		logic [ukm_pkg::SLOT_W-1:0]  slot;
		logic [ukm_pkg::BYTES_W-1:0] text;
		logic [ukm_pkg::LEN_W-1:0]   len;
	} command_t;

	typedef struct {
		logic [ukm_pkg::POS_W-1:0] pos;
		ukm_pkg::status_t          st;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [ukm_pkg::CMD_W-1:0]    cmd = ukm_pkg::CMD_LOAD;
	logic [ukm_pkg::SLOT_W-1:0]   entry_index = '0;
	logic [ukm_pkg::BYTES_W-1:0]  text_bytes = '0;
	logic [ukm_pkg::LEN_W-1:0]    text_length = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [ukm_pkg::POS_W-1:0]    position;
	logic [ukm_pkg::STAT_W-1:0]   status;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [ukm_pkg::LIST_W-1:0]   cfg_data = '0;

	// Predictor copy of the keyword table and list length
	logic [ukm_pkg::BYTES_W-1:0] kw_text [TABLE_DEPTH];
	int unsigned                 kw_len  [TABLE_DEPTH];
	logic [ukm_pkg::LIST_W-1:0]  list_len_q = '0;

	// Generator's own view of the table, used to build prefix lookups
	logic [ukm_pkg::BYTES_W-1:0] gen_text [TABLE_DEPTH];
	int unsigned                 gen_len  [TABLE_DEPTH];

	command_t command_q [$];
	verdict_t verdict_q [$];
	int       outstanding = 0;
	int       errors = 0;
	bit       send_idle_on = 1'b1;
	bit       recv_stall_on = 1'b1;
	int       gap_cnt = 0;
	int       stall_cnt = 0;

	unique_prefix_keyword_matcher_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.entry_index (entry_index),
		.text_bytes  (text_bytes),
		.text_length (text_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Keep only the low n bytes
	function automatic logic [ukm_pkg::BYTES_W-1:0] keep_bytes(
			input logic [ukm_pkg::BYTES_W-1:0] t, input int unsigned n);
		if (n >= WORD_BYTES) begin
			return t;
		end
		return t & ((ukm_pkg::BYTES_W'(1) << (8 * n)) - ukm_pkg::BYTES_W'(1));
	endfunction

	function automatic int unsigned clamp_len(input logic [ukm_pkg::LEN_W-1:0] len);
		return (len > WORD_BYTES) ? WORD_BYTES : int'(len);
	endfunction

	// Scan the active part of the table for the word
	function automatic verdict_t resolve_lookup(input logic [ukm_pkg::BYTES_W-1:0] bytes_in,
			input logic [ukm_pkg::LEN_W-1:0] len_in);
		verdict_t                    v;
		int unsigned                 len;
		int unsigned                 cnt;
		int unsigned                 first;
		bit                          have_first;
		bit                          done;
		logic [ukm_pkg::BYTES_W-1:0] word;
		len = clamp_len(len_in);
		word = keep_bytes(bytes_in, len);
		cnt = (list_len_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(list_len_q);
		have_first = 1'b0;
		done = 1'b0;
		first = 0;
		v.pos = '0;
		v.st = ukm_pkg::ST_NOT_FOUND;
		for (int unsigned n = 0; n < cnt && !done; n++) begin
			if (kw_len[n] >= len && keep_bytes(kw_text[n], len) == word) begin
				if (kw_len[n] == len) begin
					v.pos = ukm_pkg::POS_W'(n + 1);
					v.st = ukm_pkg::ST_EXACT;
					done = 1'b1;
				end else if (!have_first) begin
					have_first = 1'b1;
					first = n;
				end else begin
					v.pos = '0;
					v.st = ukm_pkg::ST_AMBIGUOUS;
					done = 1'b1;
				end
			end
		end
		if (!done && have_first) begin
			v.pos = ukm_pkg::POS_W'(first + 1);
			v.st = ukm_pkg::ST_ABBREV;
		end
		return v;
	endfunction

	// Update the table or resolve the word, and record the expected result
	task automatic apply_command(input logic [ukm_pkg::CMD_W-1:0] op,
			input logic [ukm_pkg::SLOT_W-1:0] slot,
			input logic [ukm_pkg::BYTES_W-1:0] text, input logic [ukm_pkg::LEN_W-1:0] len);
		verdict_t v;
		if (op == ukm_pkg::CMD_LOAD) begin
			if (slot < TABLE_DEPTH) begin
				kw_text[slot] = keep_bytes(text, clamp_len(len));
				kw_len[slot] = clamp_len(len);
			end
			v.pos = '0;
			v.st = ukm_pkg::ST_LOADED;
		end else begin
			v = resolve_lookup(text, len);
		end
		verdict_q.push_back(v);
	endtask

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	function automatic logic [ukm_pkg::BYTES_W-1:0] ascii(input string s);
		logic [ukm_pkg::BYTES_W-1:0] t;
		t = '0;
		for (int i = 0; i < s.len() && i < WORD_BYTES; i++) begin
			t[8*i +: 8] = s[i];
		end
		return t;
	endfunction

	task automatic queue_item(input logic [ukm_pkg::CMD_W-1:0] op, input int unsigned slot,
			input logic [ukm_pkg::BYTES_W-1:0] text, input int unsigned len);
		command_t c;
		c.op = op;
		c.slot = ukm_pkg::SLOT_W'(slot);
		c.text = text;
		c.len = ukm_pkg::LEN_W'(len);
		command_q.push_back(c);
		outstanding++;
	endtask

	// Mostly a small alphabet so that keywords share prefixes
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 19))
			0: return 8'h00;
			1: return 8'($urandom);
			default: return 8'h61 + 8'($urandom_range(0, 2));
		endcase
	endfunction

	// Random junk everywhere, then n characters in the low bytes
	function automatic logic [ukm_pkg::BYTES_W-1:0] rand_text(input int unsigned n);
		logic [ukm_pkg::BYTES_W-1:0] t;
		t = {$urandom, $urandom};
		for (int unsigned i = 0; i < n && i < WORD_BYTES; i++) begin
			t[8*i +: 8] = pick_char();
		end
		return t;
	endfunction

	function automatic int unsigned rand_kw_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(6, 8);
			2: return $urandom_range(9, 15);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	task automatic queue_load(input int unsigned slot);
		int unsigned                 len;
		logic [ukm_pkg::BYTES_W-1:0] text;
		len = rand_kw_len();
		text = rand_text(len);
		queue_item(ukm_pkg::CMD_LOAD, slot, text, len);
		gen_text[slot] = keep_bytes(text, clamp_len(ukm_pkg::LEN_W'(len)));
		gen_len[slot] = clamp_len(ukm_pkg::LEN_W'(len));
	endtask

	// One random item: loads, prefix lookups of known keywords, short words, noise
	task automatic queue_random(input int unsigned list_len);
		int unsigned                 r;
		int unsigned                 scanned;
		int unsigned                 slot;
		int unsigned                 n;
		logic [ukm_pkg::BYTES_W-1:0] word;
		r = $urandom_range(0, 99);
		scanned = (list_len > TABLE_DEPTH) ? TABLE_DEPTH : list_len;
		if (r < 30) begin
			queue_load($urandom_range(0, TABLE_DEPTH - 1));
		end else if (r < 75) begin
			slot = (scanned > 0) ? $urandom_range(0, scanned - 1)
				: $urandom_range(0, TABLE_DEPTH - 1);
			n = $urandom_range(0, gen_len[slot]);
			word = {$urandom, $urandom};
			for (int unsigned i = 0; i < n; i++) begin
				word[8*i +: 8] = gen_text[slot][8*i +: 8];
			end
			// near miss on the last character
			if (n > 0 && $urandom_range(0, 4) == 0) begin
				word[8*(n-1) +: 8] = word[8*(n-1) +: 8] ^ 8'h01;
			end
			if (n == WORD_BYTES && $urandom_range(0, 2) == 0) begin
				n = WORD_BYTES + $urandom_range(0, 7);
			end
			queue_item(ukm_pkg::CMD_LOOKUP, $urandom_range(0, TABLE_DEPTH - 1), word, n);
		end else if (r < 90) begin
			n = $urandom_range(0, 4);
			queue_item(ukm_pkg::CMD_LOOKUP, $urandom_range(0, TABLE_DEPTH - 1),
				rand_text(n), n);
		end else begin
			queue_item(ukm_pkg::CMD_LOOKUP, $urandom_range(0, TABLE_DEPTH - 1),
				{$urandom, $urandom}, $urandom_range(0, 15));
		end
	endtask

	task automatic write_list_length(input int unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ukm_pkg::LIST_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		list_len_q = ukm_pkg::LIST_W'(v);
	endtask

	// Wait for every result, then let the block go quiet
	task automatic settle();
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Input driver: presents queued commands, with random gaps between beats
	always @(posedge clk) begin : drive_p
		command_t c;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_command(cmd, entry_index, text_bytes, text_length);
			end
			if (!in_valid || in_ready) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					in_valid <= 1'b0;
				end else if (send_idle_on && command_q.size() > 0
						&& $urandom_range(0, 5) == 0) begin
					gap_cnt = $urandom_range(1, 15) - 1;
					in_valid <= 1'b0;
				end else if (command_q.size() > 0) begin
					c = command_q.pop_front();
					in_valid <= 1'b1;
					cmd <= c.op;
					entry_index <= c.slot;
					text_bytes <= c.text;
					text_length <= c.len;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each beat against the oldest expectation
	always @(posedge clk) begin : watch_p
		verdict_t v;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report("result with nothing pending, status", int'(status), -1);
				end else begin
					v = verdict_q.pop_front();
					outstanding--;
					if (position !== v.pos) begin
						report("position", int'(position), int'(v.pos));
					end
					if (status !== v.st) begin
						report("status", int'(status), int'(v.st));
					end
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else if (recv_stall_on && $urandom_range(0, 5) == 0) begin
				stall_cnt = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Main sequence
	initial begin : main_p
		int unsigned lim;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list after reset: nothing can match
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("list"), 4);
		// directed table; junk above the length must not be stored
		queue_item(ukm_pkg::CMD_LOAD, 0, 64'hdead_beef_0000_0000 | ascii("list"), 4);
		queue_item(ukm_pkg::CMD_LOAD, 1, '1, 0);
		queue_item(ukm_pkg::CMD_LOAD, 2, ascii("load"), 4);
		queue_item(ukm_pkg::CMD_LOAD, 3, ascii("lo"), 2);
		queue_item(ukm_pkg::CMD_LOAD, 4, 64'hffff_ffff_ff7a_0078, 3);
		queue_item(ukm_pkg::CMD_LOAD, 5, '1, 15);
		queue_item(ukm_pkg::CMD_LOAD, 15, ascii("zz"), 2);
		settle();
		write_list_length(6);
		queue_item(ukm_pkg::CMD_LOOKUP, 15, ascii("list"), 4);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("li"), 2);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("l"), 1);
		// first candidate is an abbreviation, a later one exact
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("lo"), 2);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("loa"), 3);
		// empty word hits the empty keyword
		queue_item(ukm_pkg::CMD_LOOKUP, 0, '1, 0);
		// zero byte inside the word, ones above it
		queue_item(ukm_pkg::CMD_LOOKUP, 0, 64'hffff_ffff_ffff_0078, 2);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("zz"), 2);
		// overlong length saturates to a full word
		queue_item(ukm_pkg::CMD_LOOKUP, 0, '1, 9);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("listing"), 7);
		settle();
		write_list_length(2);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, ascii("l"), 1);
		queue_item(ukm_pkg::CMD_LOOKUP, 0, 64'h0, 0);
		settle();

		// random phases, each under its own list length
		for (int unsigned p = 0; p < PHASES; p++) begin
			lim = (LIST_PLAN[p] < 0) ? $urandom_range(0, 31) : LIST_PLAN[p];
			send_idle_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			recv_stall_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			write_list_length(lim);
			if (p == 0) begin
				for (int unsigned s = 0; s < TABLE_DEPTH; s++) begin
					queue_load(s);
				end
			end
			repeat (PHASE_ITEMS) queue_random(lim);
			settle();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
